### rtl/core/ffba_pkg.sv
// Package for the first-fit block table allocator.
// Holds the status codes, field widths and the request token that moves down the cell chain.
// No dependencies.
`default_nettype none

package ffba_pkg;

  localparam int unsigned FieldW        = 12;
  localparam int unsigned DefHeapBytes  = 4096;
  localparam int unsigned DefTableDepth = 64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_HEAP_FULL  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef struct packed {
    logic              valid;
    req_e              req;
    logic [FieldW-1:0] size;
    logic [FieldW-1:0] addr;
    logic              done;
    logic              append;
    status_e           status;
    logic [FieldW-1:0] res;
  } tok_t;

endpackage

`default_nettype wire

### rtl/core/first_fit_block_table_allocator_unit.sv
// First-fit block table allocator: a chain of TABLE_ENTRIES entry cells that one request walks.
// The first cell registers the request token on the input transfer, each later cell registers
// it from the cell before, and the result register captures what leaves the last cell.
// A new request is taken only once the current one has left the cell chain;
// a waiting result does not block the next input transfer.
// Reset clears entry count, end offset and all handshake state; entry contents are not reset.
// Depends on ffba_pkg and ffba_cell.
`default_nettype none

module first_fit_block_table_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned HEAP_BYTES    = DefHeapBytes,
  parameter int unsigned TABLE_ENTRIES = DefTableDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic [FieldW-1:0] alloc_size_i,
  input  wire logic [FieldW-1:0] addr_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [1:0]        status_o,
  output      logic [FieldW-1:0] block_addr_o
);

  localparam int unsigned OW = $clog2(HEAP_BYTES);
  localparam int unsigned SW = (OW > FieldW) ? OW : FieldW;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [SW:0] HeapLast = (SW+1)'(HEAP_BYTES - 1);

  tok_t              chain [TABLE_ENTRIES+1];
  tok_t              head;
  logic              busy_q;
  logic [CW-1:0]     count_q;
  logic [SW-1:0]     end_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [FieldW-1:0] addr_q;
  logic              adv, in_xfer, exit_xfer, reject;
  logic [SW:0]       sum;
  tok_t              last;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign sum        = {1'b0, end_q} + (SW+1)'(alloc_size_i);
  assign reject     = (alloc_size_i == '0) || (sum > HeapLast);

  always_comb begin
    head        = '0;
    head.valid  = in_xfer;
    head.req    = req_e'(req_type_i);
    head.size   = alloc_size_i;
    head.addr   = addr_i;
    head.status = ST_OK;
    if (req_e'(req_type_i) == REQ_ALLOC && reject) begin
      head.done   = 1'b1;
      head.status = ST_HEAP_FULL;
    end
  end

  assign chain[0]  = head;
  assign last      = chain[TABLE_ENTRIES];
  assign adv       = !(last.valid && out_valid_q && !out_ready_i);
  assign exit_xfer = last.valid && adv;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ffba_cell #(
      .IDX(g),
      .CW (CW),
      .SW (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .count_i(count_q),
      .end_i  (end_q),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (exit_xfer) begin
        busy_q <= 1'b0;
      end
      if (exit_xfer && last.append) begin
        count_q <= count_q + CW'(1);
        end_q   <= end_q + SW'(last.size);
      end
      if (exit_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_xfer) begin
      if (last.done) begin
        status_q <= last.status;
        addr_q   <= last.res;
      end else begin
        status_q <= (last.req == REQ_ALLOC) ? ST_TABLE_FULL : ST_NOT_FOUND;
        addr_q   <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign block_addr_o = addr_q;

endmodule

`default_nettype wire

### rtl/core/ffba_cell.sv
// One table entry of the allocator chain: start, size and free mark of a block.
// Checks the passing request token and forwards it to the next cell. Depends on ffba_pkg.
`default_nettype none

module ffba_cell import ffba_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned SW  = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic [CW-1:0] count_i,
  input  wire logic [SW-1:0] end_i,
  input  wire tok_t          tok_i,
  output tok_t               tok_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [SW-1:0]     start_q, start_d;
  logic [FieldW-1:0] size_q, size_d;
  logic              free_q, free_d;
  tok_t              tok_q, tok_d;
  logic              live, at_end;

  assign live   = IdxC < count_i;
  assign at_end = IdxC == count_i;

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    free_d  = free_q;
    tok_d   = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      unique case (tok_i.req)
        REQ_ALLOC: begin
          if (live && free_q && (size_q >= tok_i.size)) begin
            free_d       = 1'b0;
            tok_d.done   = 1'b1;
            tok_d.status = ST_OK;
            tok_d.res    = start_q[FieldW-1:0];
          end else if (at_end) begin
            start_d      = end_i;
            size_d       = tok_i.size;
            free_d       = 1'b0;
            tok_d.done   = 1'b1;
            tok_d.append = 1'b1;
            tok_d.status = ST_OK;
            tok_d.res    = end_i[FieldW-1:0];
          end
        end
        REQ_FREE: begin
          if (live && (start_q == SW'(tok_i.addr))) begin
            free_d       = 1'b1;
            tok_d.done   = 1'b1;
            tok_d.status = ST_OK;
            tok_d.res    = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      start_q <= start_d;
      size_q  <= size_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### rtl/core/ffba_checker.sv
// Port-level checks for the first-fit block table allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_table_allocator_unit.
`default_nettype none

module ffba_checker import ffba_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [1:0]        status_o,
  input wire logic [FieldW-1:0] block_addr_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(block_addr_o))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken during a scan");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after input transfer");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> block_addr_o == '0)
    else $error("nonzero address with error status");

endmodule

bind first_fit_block_table_allocator_unit ffba_checker u_ffba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .block_addr_o(block_addr_o)
);

`default_nettype wire
